// File: hw/rtl/wacbc_pkg.sv
// ----------------------------------------------------------------------------
// wacbc_pkg
// Shared types and constants for the warp access coalescing / bank counter.
// ----------------------------------------------------------------------------
package wacbc_pkg;

    localparam int KEY_W   = 32;  // address width, also the key width
    localparam int COST_W  = 7;   // holds up to 64 lanes or keys
    localparam int OUT_W   = 6;   // reported cost, saturating
    localparam int CNT_W   = 48;
    localparam int NUM_CNT = 8;

    // event counter slots, in output order
    localparam int CNT_GLOBAL_LOAD   = 0;
    localparam int CNT_GLOBAL_STORE  = 1;
    localparam int CNT_GLOBAL_LANES  = 2;
    localparam int CNT_GLOBAL_SEGS   = 3;
    localparam int CNT_SHARED_ACC    = 4;
    localparam int CNT_SHARED_LANES  = 5;
    localparam int CNT_SHARED_WAVES  = 6;
    localparam int CNT_SHARED_CONFL  = 7;

    localparam logic [OUT_W-1:0] COST_MAX = '1;

    typedef struct packed {
        logic shared;
        logic store;
        logic active;
        logic last;
    } lane_flags_t;

    // finished access handed from the key tracker to the counters
    typedef struct packed {
        logic              shared;
        logic              store;
        logic [COST_W-1:0] lanes;
        logic [COST_W-1:0] cost;
    } fin_t;

endpackage

// File: hw/rtl/wacbc_fifo.sv
// ----------------------------------------------------------------------------
// wacbc_fifo
// Small register queue between the classify pipeline and the key tracker.
// ----------------------------------------------------------------------------
module wacbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hw/rtl/wacbc_front.sv
// ----------------------------------------------------------------------------
// wacbc_front
// Accepts lane items and classifies them: forms the key (segment number or
// address) and the bank index through constant reciprocal multiplies.
// ----------------------------------------------------------------------------
module wacbc_front #(
    parameter int SEG_SIZE   = 128,
    parameter int WORD_BYTES = 4,
    parameter int BANKS      = 32,
    parameter int ENTRY_W    = 41
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         kind,
    input  logic               lane_active,
    input  logic [31:0]        address,
    input  logic               last_lane,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data,
    input  logic               q_full
);

    import wacbc_pkg::*;

    localparam int BANK_IW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int RCP_W   = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RCP_W;

    // exact reciprocal: m = ceil(2^(32+l) / d), l = ceil(log2 d)
    localparam int SEG_SH = KEY_W + $clog2(SEG_SIZE);
    localparam int BW_SH  = KEY_W + $clog2(WORD_BYTES);
    localparam int BK_SH  = KEY_W + $clog2(BANKS);
    localparam logic [63:0] SEG_RCP =
        ((64'd1 << SEG_SH) + 64'(SEG_SIZE) - 64'd1) / 64'(SEG_SIZE);
    localparam logic [63:0] BW_RCP =
        ((64'd1 << BW_SH) + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES);
    localparam logic [63:0] BK_RCP =
        ((64'd1 << BK_SH) + 64'(BANKS) - 64'd1) / 64'(BANKS);

    logic adv;

    logic              s1_v_reg;
    logic [KEY_W-1:0]  s1_addr_reg;
    lane_flags_t       s1_flags_reg;

    logic              s2_v_reg;
    logic [KEY_W-1:0]  s2_key_reg;
    logic [KEY_W-1:0]  s2_word_reg;
    lane_flags_t       s2_flags_reg;

    logic              s3_v_reg;
    logic [KEY_W-1:0]  s3_key_reg;
    logic [BANK_IW-1:0] s3_word_lo_reg;
    logic [BANK_IW-1:0] s3_quo_lo_reg;
    lane_flags_t       s3_flags_reg;

    lane_flags_t        in_flags;
    logic [PROD_W-1:0]  seg_prod, bw_prod, bk_prod;
    logic [KEY_W-1:0]   seg_q, bw_q, bk_q;
    logic [BANK_IW-1:0] bank;

    assign adv    = !s3_v_reg || !q_full;
    assign full   = !adv;
    assign q_push = s3_v_reg && !q_full;

    // kind bit 1 selects shared, so kind 3 is shared as well
    always_comb
    begin
        in_flags.shared = kind[1];
        in_flags.store  = kind[0];
        in_flags.active = lane_active;
        in_flags.last   = last_lane;
    end

    assign seg_prod = {{RCP_W{1'b0}}, s1_addr_reg} * {{KEY_W{1'b0}}, SEG_RCP[RCP_W-1:0]};
    assign bw_prod  = {{RCP_W{1'b0}}, s1_addr_reg} * {{KEY_W{1'b0}}, BW_RCP[RCP_W-1:0]};
    assign seg_q    = KEY_W'(seg_prod >> SEG_SH);
    assign bw_q     = KEY_W'(bw_prod >> BW_SH);

    assign bk_prod  = {{RCP_W{1'b0}}, s2_word_reg} * {{KEY_W{1'b0}}, BK_RCP[RCP_W-1:0]};
    assign bk_q     = KEY_W'(bk_prod >> BK_SH);

    // remainder is below BANKS, so the low bits are enough
    assign bank   = s3_word_lo_reg - BANK_IW'(s3_quo_lo_reg * BANK_IW'(BANKS));
    assign q_data = {s3_key_reg, bank, s3_flags_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= push;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_addr_reg    <= address;
            s1_flags_reg   <= in_flags;
            s2_key_reg     <= s1_flags_reg.shared ? s1_addr_reg : seg_q;
            s2_word_reg    <= bw_q;
            s2_flags_reg   <= s1_flags_reg;
            s3_key_reg     <= s2_key_reg;
            s3_word_lo_reg <= s2_word_reg[BANK_IW-1:0];
            s3_quo_lo_reg  <= bk_q[BANK_IW-1:0];
            s3_flags_reg   <= s2_flags_reg;
        end
    end

endmodule

// File: hw/rtl/wacbc_back.sv
// ----------------------------------------------------------------------------
// wacbc_back
// Key tracker: keeps the distinct keys and per-bank fills of the current
// access and hands a finished access to the counters at its last lane.
// ----------------------------------------------------------------------------
module wacbc_back #(
    parameter int LANES   = 32,
    parameter int BANKS   = 32,
    parameter int ENTRY_W = 41
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               q_pop,
    output logic               fin_valid,
    output wacbc_pkg::fin_t    fin,
    input  logic               fin_take
);

    import wacbc_pkg::*;

    localparam int BANK_IW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int KEY_IW  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int FILL_W  = $clog2(LANES + 1);

    logic [KEY_W-1:0]  keys_reg [LANES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] bank_reg [BANKS];
    logic [FILL_W-1:0] worst_reg, worst_next;
    logic [FILL_W-1:0] act_reg, act_next;
    logic              fin_v_reg, fin_v_next;
    fin_t              fin_reg, fin_data;

    logic [KEY_W-1:0]   key;
    logic [BANK_IW-1:0] bank;
    lane_flags_t        flags;
    logic               fin_free, hit, ins, bank_ins;
    logic [FILL_W-1:0]  fill_inc, bcnt_new, worst_upd, act_inc;

    assign {key, bank, flags} = q_data;

    assign fin_free  = !fin_v_reg || fin_take;
    assign q_pop     = !q_empty && (!flags.last || fin_free);
    assign fin_valid = fin_v_reg;
    assign fin       = fin_reg;

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if ((FILL_W'(i) < fill_reg) && (keys_reg[i] == key))
            begin
                hit = 1'b1;
            end
        end
    end

    // a new key that finds the store full is dropped
    assign ins      = flags.active && !hit && (fill_reg < FILL_W'(LANES));
    assign bank_ins = ins && flags.shared;
    assign fill_inc = fill_reg + FILL_W'(ins);
    assign bcnt_new = bank_reg[bank] + 1'b1;
    assign worst_upd = (bank_ins && (bcnt_new > worst_reg)) ? bcnt_new : worst_reg;
    assign act_inc  = (flags.active && (act_reg < FILL_W'(LANES))) ? act_reg + 1'b1 : act_reg;

    always_comb
    begin
        fill_next  = fill_reg;
        worst_next = worst_reg;
        act_next   = act_reg;
        fin_v_next = fin_v_reg && !fin_take;
        fin_data.shared = flags.shared;
        fin_data.store  = flags.store;
        fin_data.lanes  = COST_W'(act_inc);
        fin_data.cost   = flags.shared ? COST_W'(worst_upd) : COST_W'(fill_inc);
        if (q_pop)
        begin
            if (flags.last)
            begin
                fill_next  = '0;
                worst_next = '0;
                act_next   = '0;
                if (act_inc != '0)
                begin
                    fin_v_next = 1'b1;
                end
            end
            else
            begin
                fill_next  = fill_inc;
                worst_next = worst_upd;
                act_next   = act_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            worst_reg <= '0;
            act_reg   <= '0;
            fin_v_reg <= 1'b0;
            for (int b = 0; b < BANKS; b++)
            begin
                bank_reg[b] <= '0;
            end
        end
        else
        begin
            fill_reg  <= fill_next;
            worst_reg <= worst_next;
            act_reg   <= act_next;
            fin_v_reg <= fin_v_next;
            if (q_pop && flags.last)
            begin
                for (int b = 0; b < BANKS; b++)
                begin
                    bank_reg[b] <= '0;
                end
            end
            else if (q_pop && bank_ins)
            begin
                bank_reg[bank] <= bcnt_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && ins)
        begin
            keys_reg[fill_reg[KEY_IW-1:0]] <= key;
        end
        if (q_pop && flags.last && fin_free)
        begin
            fin_reg <= fin_data;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LANES))
        else $error("key fill beyond lane count");

    a_fill_le_act: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= act_reg)
        else $error("more keys than active lanes");

    a_worst_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        worst_reg <= fill_reg)
        else $error("bank degree above key count");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_v_reg && !fin_take |=> fin_v_reg && $stable(fin_reg))
        else $error("finished access lost before transfer");

endmodule

// File: hw/rtl/wacbc_stats.sv
// ----------------------------------------------------------------------------
// wacbc_stats
// Eight wrapping event counters and the result register.
// ----------------------------------------------------------------------------
module wacbc_stats (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fin_valid,
    input  wacbc_pkg::fin_t          fin,
    output logic                     fin_take,
    output logic                     empty,
    input  logic                     pop,
    output logic [wacbc_pkg::OUT_W-1:0] access_cost,
    output logic [wacbc_pkg::CNT_W-1:0] counts [wacbc_pkg::NUM_CNT]
);

    import wacbc_pkg::*;

    logic [CNT_W-1:0] cnt_reg  [NUM_CNT];
    logic [CNT_W-1:0] cnt_next [NUM_CNT];
    logic             out_v_reg;
    logic [OUT_W-1:0] cost_reg;
    logic [CNT_W-1:0] lanes_ext, cost_ext;

    // counters only move when a new result loads, so they double as output
    assign fin_take    = fin_valid && (!out_v_reg || pop);
    assign empty       = !out_v_reg;
    assign access_cost = cost_reg;
    assign lanes_ext   = CNT_W'(fin.lanes);
    assign cost_ext    = CNT_W'(fin.cost);

    always_comb
    begin
        for (int c = 0; c < NUM_CNT; c++)
        begin
            cnt_next[c] = cnt_reg[c];
        end
        if (fin.shared)
        begin
            cnt_next[CNT_SHARED_ACC]   = cnt_reg[CNT_SHARED_ACC] + 1'b1;
            cnt_next[CNT_SHARED_LANES] = cnt_reg[CNT_SHARED_LANES] + lanes_ext;
            cnt_next[CNT_SHARED_WAVES] = cnt_reg[CNT_SHARED_WAVES] + cost_ext;
            if (fin.cost > COST_W'(1))
            begin
                cnt_next[CNT_SHARED_CONFL] = cnt_reg[CNT_SHARED_CONFL] + 1'b1;
            end
        end
        else
        begin
            if (fin.store)
            begin
                cnt_next[CNT_GLOBAL_STORE] = cnt_reg[CNT_GLOBAL_STORE] + 1'b1;
            end
            else
            begin
                cnt_next[CNT_GLOBAL_LOAD] = cnt_reg[CNT_GLOBAL_LOAD] + 1'b1;
            end
            cnt_next[CNT_GLOBAL_LANES] = cnt_reg[CNT_GLOBAL_LANES] + lanes_ext;
            cnt_next[CNT_GLOBAL_SEGS]  = cnt_reg[CNT_GLOBAL_SEGS] + cost_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            for (int c = 0; c < NUM_CNT; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            if (fin_take)
            begin
                out_v_reg <= 1'b1;
                cnt_reg   <= cnt_next;
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_take)
        begin
            cost_reg <= fin.cost[COST_W-1] ? COST_MAX : fin.cost[OUT_W-1:0];
        end
    end

    assign counts = cnt_reg;

    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fin_take |=> $stable(cnt_reg[CNT_GLOBAL_LANES]) && $stable(cnt_reg[CNT_SHARED_LANES]))
        else $error("counter moved without a finished access");

endmodule

// File: hw/rtl/warp_access_coalesce_bank_counter.sv
// ----------------------------------------------------------------------------
// warp_access_coalesce_bank_counter
// Counts coalesced segments of global accesses and bank conflict degree of
// shared accesses, keeping eight wrapping event counters.
// ----------------------------------------------------------------------------
// A warp access arrives as a run of lane items, one per transfer, closed by
// last_lane. The block takes one lane item per clock when nothing stalls:
// a three-stage classify pipeline forms the key and bank with constant
// reciprocal multiplies, a four-entry queue decouples it from the key
// tracker, which compares each key against all stored keys at once.
// After the last lane of an access with an active lane, the result passes
// through the tracker's finished register into the result register and stays
// until popped; the counters shown are their values after that access.
// Accesses with no active lane produce no result.
module warp_access_coalesce_bank_counter #(
    parameter int LANES      = 32,
    parameter int BANKS      = 32,
    parameter int SEG_SIZE   = 128,
    parameter int WORD_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic        lane_active,
    input  logic [31:0] address,
    input  logic        last_lane,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  access_cost,
    output logic [47:0] global_load_count,
    output logic [47:0] global_store_count,
    output logic [47:0] global_lane_total,
    output logic [47:0] global_segment_total,
    output logic [47:0] shared_access_count,
    output logic [47:0] shared_lane_total,
    output logic [47:0] shared_wavefront_total,
    output logic [47:0] shared_conflict_count
);

    import wacbc_pkg::*;

    localparam int BANK_IW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int ENTRY_W = KEY_W + BANK_IW + $bits(lane_flags_t);
    localparam int Q_DEPTH = 4;

    logic               q_push, q_full, q_pop, q_empty;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;
    logic               fin_valid, fin_take;
    fin_t               fin;
    logic [CNT_W-1:0]   counts [NUM_CNT];

    wacbc_front #(
        .SEG_SIZE   (SEG_SIZE),
        .WORD_BYTES (WORD_BYTES),
        .BANKS      (BANKS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .lane_active (lane_active),
        .address     (address),
        .last_lane   (last_lane),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    wacbc_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    wacbc_back #(
        .LANES   (LANES),
        .BANKS   (BANKS),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_take  (fin_take)
    );

    wacbc_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .fin_valid   (fin_valid),
        .fin         (fin),
        .fin_take    (fin_take),
        .empty       (empty),
        .pop         (pop),
        .access_cost (access_cost),
        .counts      (counts)
    );

    assign global_load_count      = counts[CNT_GLOBAL_LOAD];
    assign global_store_count     = counts[CNT_GLOBAL_STORE];
    assign global_lane_total      = counts[CNT_GLOBAL_LANES];
    assign global_segment_total   = counts[CNT_GLOBAL_SEGS];
    assign shared_access_count    = counts[CNT_SHARED_ACC];
    assign shared_lane_total      = counts[CNT_SHARED_LANES];
    assign shared_wavefront_total = counts[CNT_SHARED_WAVES];
    assign shared_conflict_count  = counts[CNT_SHARED_CONFL];

endmodule
